/* sv/sync_length_checksum_deframer_top_assert.svh */
// Assertion macros for the deframer checker file.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define SLCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled while rst is high
`define SLCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

/* sv/slcd_pkg.sv */
// Shared constants and types for the sync/length/checksum deframer.
package slcd_pkg;

   // frame store geometry: two banks of one frame each
   localparam int FRAME_DEPTH = 64;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int STORE_DEPTH = 2 * FRAME_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // header and framing constants
   localparam logic [7:0] HDR_FIRST      = 8'hFF;
   localparam logic [7:0] HDR_SECOND     = 8'hAA;
   localparam logic [5:0] LIMIT_RESET    = 6'd50;
   localparam int         FRAME_OVERHEAD = 4;
   localparam int         HDR_LEN        = 3;
   localparam logic [7:0] LEN_CAP        = 8'(FRAME_DEPTH - FRAME_OVERHEAD);

   // store index of the length byte
   localparam logic [ADDR_W-1:0] LEN_IDX = ADDR_W'(2);

   // one verified frame waiting for emission
   typedef struct packed {
      logic              bank;
      logic [ADDR_W-1:0] total;   // index of the checksum byte
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } queue_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* sv/slcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module slcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/slcd_front.sv */
// Front end: header hunt, length check, body capture and checksum verify.
module slcd_front import slcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                csr_wr_en,
   input  logic [5:0]          csr_wr_data,
   input  queue_status_type    q_status,
   output queue_push_type      q_push,
   output logic                st_wr_en,
   output logic [STORE_AW-1:0] st_wr_addr,
   output logic [7:0]          st_wr_data
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SECOND,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] held_ff, held_in;
   logic [ADDR_W-1:0] total_ff, total_in;
   logic [7:0]        sum_ff, sum_in;
   logic              bank_ff, bank_in;
   logic [5:0]        limit_ff;
   logic [7:0]        eff_limit;
   logic              accept;
   logic              push;

   // both banks hold unsent frames: hold off the sender
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // limit saturates so a frame always fits one bank
   assign eff_limit = ({2'b00, limit_ff} > LEN_CAP) ? LEN_CAP : {2'b00, limit_ff};

   // next-state, store write and push decode
   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      total_in   = total_ff;
      sum_in     = sum_ff;
      bank_in    = bank_ff;
      push       = 1'b0;
      st_wr_en   = 1'b0;
      st_wr_addr = {bank_ff, held_ff};
      st_wr_data = req_rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == HDR_FIRST) phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               if (req_rx_byte == HDR_SECOND) phase_in = PH_LENGTH;
               else if (req_rx_byte != HDR_FIRST) phase_in = PH_HUNT;
            end
            PH_LENGTH: begin
               if (req_rx_byte > eff_limit) begin
                  phase_in = (req_rx_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
               end else begin
                  // header bytes are constants; only the length is stored
                  st_wr_en   = 1'b1;
                  st_wr_addr = {bank_ff, LEN_IDX};
                  held_in    = ADDR_W'(HDR_LEN);
                  total_in   = ADDR_W'(req_rx_byte) + ADDR_W'(HDR_LEN);
                  sum_in     = req_rx_byte;
                  phase_in   = PH_BODY;
               end
            end
            PH_BODY: begin
               st_wr_en = 1'b1;
               if (held_ff == total_ff) begin
                  if (req_rx_byte == sum_ff) begin
                     push    = 1'b1;
                     bank_in = !bank_ff;
                  end
                  phase_in = PH_HUNT;
                  held_in  = '0;
               end else begin
                  sum_in  = sum_ff + req_rx_byte;
                  held_in = held_ff + ADDR_W'(1);
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   assign q_push.valid      = push;
   assign q_push.desc.bank  = bank_ff;
   assign q_push.desc.total = total_ff;

   // state and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         held_ff  <= '0;
         total_ff <= '0;
         sum_ff   <= '0;
         bank_ff  <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         bank_ff  <= bank_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

endmodule

/* sv/slcd_queue.sv */
// Two-entry queue of verified frame descriptors between front and back.
module slcd_queue import slcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_push_type   q_push,
   input  logic             q_pop,
   output desc_type         q_head,
   output queue_status_type q_status
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign q_head         = entry_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_status.full;
   assign do_pop  = q_pop && !q_status.empty;

   // payload entries
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= q_push.desc;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* sv/slcd_back.sv */
// Back end: reads a verified frame from its bank and sends it word by word.
module slcd_back import slcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  desc_type            q_head,
   input  queue_status_type    q_status,
   output logic                q_pop,
   output logic [STORE_AW-1:0] st_rd_addr,
   input  logic [7:0]          st_rd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_frame_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SHOW
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [ADDR_W-1:0] total_ff;
   logic              bank_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;
   logic              taken;

   assign st_rd_addr     = {bank_ff, idx_ff};
   assign rsp_valid      = (state_ff == ST_SHOW);
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_last = last_ff;
   assign taken          = rsp_valid && !rsp_stall;
   // the frame's bank is released once its checksum word is taken
   assign q_pop          = taken && last_ff;

   // emission sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         total_ff <= '0;
         bank_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  bank_ff  <= q_head.bank;
                  total_ff <= q_head.total;
                  idx_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end
            // address is up this cycle, data lands next cycle
            ST_READ: state_ff <= ST_LOAD;
            ST_LOAD: begin
               // header words are regenerated, the rest comes from the store
               if (idx_ff == ADDR_W'(0))      byte_ff <= HDR_FIRST;
               else if (idx_ff == ADDR_W'(1)) byte_ff <= HDR_SECOND;
               else                           byte_ff <= st_rd_data;
               last_ff  <= (idx_ff == total_ff);
               state_ff <= ST_SHOW;
            end
            ST_SHOW: begin
               if (taken) begin
                  if (last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + ADDR_W'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* sv/sync_length_checksum_deframer_top.sv */
// Top level of the header/length/checksum deframer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_rx_byte[7:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_frame_byte[7:0], rsp_frame_last
//   csr      in         csr_wr_en            csr_wr_data[5:0] (max_payload_len)
//
// Input words are taken one per cycle; the front stalls only while both store
// banks hold frames not yet sent.
// Each output word passes through store read, load and show in turn, so a frame of
// length L leaves as L+4 words after its descriptor is fetched.
// Reset is synchronous and clears all control state; the store needs no clear.
// An output stall holds the current word; input stalls once a second frame waits.
module sync_length_checksum_deframer_top import slcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_last,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   queue_push_type      q_push;
   queue_status_type    q_status;
   desc_type            q_head;
   logic                q_pop;
   logic                st_wr_en;
   logic [STORE_AW-1:0] st_wr_addr;
   logic [7:0]          st_wr_data;
   logic [STORE_AW-1:0] st_rd_addr;
   logic [7:0]          st_rd_data;

   slcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .st_wr_en    (st_wr_en),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data)
   );

   // two frame banks, front writes one while back reads the other
   slcd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   slcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   slcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .st_rd_addr     (st_rd_addr),
      .st_rd_data     (st_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

/* sv/slcd_checker.sv */
// Port-level checker for the deframer, bound to the top level.
`include "sync_length_checksum_deframer_top_assert.svh"

module slcd_checker import slcd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_frame_last
);

   logic first_ff;
   logic second_ff;
   logic taken;

   assign taken = rsp_valid && !rsp_stall;

   // track position of the next output word within its frame
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 1'b1;
         second_ff <= 1'b0;
      end else if (taken) begin
         first_ff  <= rsp_frame_last;
         second_ff <= first_ff && !rsp_frame_last;
      end
   end

   // a stalled word holds
   `SLCD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_last))
   // every frame opens with the two header words
   `SLCD_ASSERT_IMP(a_hdr_first, clock, reset, rsp_valid && first_ff,
                    rsp_frame_byte == HDR_FIRST && !rsp_frame_last)
   `SLCD_ASSERT_IMP(a_hdr_second, clock, reset, rsp_valid && second_ff,
                    rsp_frame_byte == HDR_SECOND && !rsp_frame_last)
   // nothing leaves straight out of reset
   `SLCD_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind sync_length_checksum_deframer_top slcd_checker u_checker (.*);
